@@ src/ring_buffer_deque_macros.svh @@
// Assertion macros shared by the deque checker.
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define RBD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define RBD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

@@ src/rbd_pkg.sv @@
// Shared constants and types of the ring buffer deque.
`timescale 1ns / 1ps
package rbd_pkg;

    localparam int CAPACITY      = 16;
    localparam int ELEMENT_WIDTH = 64;
    localparam int PTR_W         = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W         = $clog2(CAPACITY + 1);

    localparam logic [1:0] ACT_PUSH_END   = 2'd0;
    localparam logic [1:0] ACT_PUSH_START = 2'd1;
    localparam logic [1:0] ACT_POP_END    = 2'd2;
    localparam logic [1:0] ACT_POP_START  = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

endpackage

@@ src/rbd_ram.sv @@
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module rbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/ring_buffer_deque.sv @@
// Top level of the ring buffer deque.
`timescale 1ns / 1ps
// Double-ended queue of rbd_pkg::CAPACITY elements held in one RAM.
// Input channel (i_in_valid / o_in_ready) carries an action and a data word:
// push at end, push at start, pop from end, pop from start. Output channel
// (o_out_valid / i_out_ready) returns one beat per action: the popped word
// (zero otherwise), a status (done, full, empty) and the count afterwards.
// A push, or any rejected action, needs no RAM read: the result sits in the
// output register the cycle after the beat is accepted. A successful pop
// goes through the S_READ state for the registered read of the element RAM;
// no new beat is taken while that read is in flight.
// Pushes are taken one per cycle while the receiver keeps up; a pop blocks input until its read is done.
// A new beat is accepted when the output register is empty or is drained in
// the same cycle; if the receiver stalls, the result holds and input stalls.
// Reset (synchronous, active low) empties the queue and clears both pointers;
// the RAM contents are not cleared and need no clearing pass.
module ring_buffer_deque (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [63:0] i_item_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_out_data,
    output logic [1:0]  o_status,
    output logic [4:0]  o_count_after
);

    localparam logic [rbd_pkg::PTR_W-1:0] PTR_LAST =
        rbd_pkg::PTR_W'(rbd_pkg::CAPACITY - 1);
    localparam logic [rbd_pkg::CNT_W-1:0] CNT_FULL =
        rbd_pkg::CNT_W'(rbd_pkg::CAPACITY);

    rbd_pkg::t_state r_state, n_state;

    logic [rbd_pkg::PTR_W-1:0] r_front, n_front;
    logic [rbd_pkg::PTR_W-1:0] r_back,  n_back;
    logic [rbd_pkg::CNT_W-1:0] r_count, n_count;

    logic                             r_out_valid;
    logic [rbd_pkg::ELEMENT_WIDTH-1:0] r_out_data;
    logic [1:0]                       r_out_status;
    logic [rbd_pkg::CNT_W-1:0]        r_out_count;

    logic                              accept;
    logic                              is_empty;
    logic                              is_full;
    logic                              mem_we;
    logic                              pop_ok;
    logic [1:0]                        status;
    logic [rbd_pkg::PTR_W-1:0]         mem_addr;
    logic [rbd_pkg::ELEMENT_WIDTH-1:0] mem_rdata;
    logic [rbd_pkg::ELEMENT_WIDTH+63:0] data_ext;
    logic [rbd_pkg::CNT_W+4:0]          count_ext;

    function automatic logic [rbd_pkg::PTR_W-1:0] step_up(
        input logic [rbd_pkg::PTR_W-1:0] p
    );
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [rbd_pkg::PTR_W-1:0] step_down(
        input logic [rbd_pkg::PTR_W-1:0] p
    );
        return (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    assign o_in_ready = (r_state == rbd_pkg::S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept     = i_in_valid && o_in_ready;
    assign is_empty   = (r_count == '0);
    assign is_full    = (r_count == CNT_FULL);

    always_comb begin
        n_front  = r_front;
        n_back   = r_back;
        n_count  = r_count;
        mem_we   = 1'b0;
        mem_addr = r_back;
        pop_ok   = 1'b0;
        status   = rbd_pkg::ST_DONE;
        case (i_action)
            rbd_pkg::ACT_PUSH_END: begin
                if (is_full) begin
                    status = rbd_pkg::ST_FULL;
                end else begin
                    mem_addr = is_empty ? r_back : step_up(r_back);
                    n_back   = mem_addr;
                    n_count  = r_count + 1'b1;
                    mem_we   = accept;
                end
            end
            rbd_pkg::ACT_PUSH_START: begin
                if (is_full) begin
                    status = rbd_pkg::ST_FULL;
                end else begin
                    mem_addr = is_empty ? r_front : step_down(r_front);
                    n_front  = mem_addr;
                    n_count  = r_count + 1'b1;
                    mem_we   = accept;
                end
            end
            rbd_pkg::ACT_POP_END: begin
                mem_addr = r_back;
                if (is_empty) begin
                    status = rbd_pkg::ST_EMPTY;
                end else begin
                    pop_ok  = 1'b1;
                    n_count = r_count - 1'b1;
                    if (n_count != '0) begin
                        n_back = step_down(r_back);
                    end
                end
            end
            rbd_pkg::ACT_POP_START: begin
                mem_addr = r_front;
                if (is_empty) begin
                    status = rbd_pkg::ST_EMPTY;
                end else begin
                    pop_ok  = 1'b1;
                    n_count = r_count - 1'b1;
                    if (n_count != '0) begin
                        n_front = step_up(r_front);
                    end
                end
            end
            default: begin
                status = rbd_pkg::ST_DONE;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            rbd_pkg::S_IDLE: begin
                if (accept && pop_ok) begin
                    n_state = rbd_pkg::S_READ;
                end
            end
            rbd_pkg::S_READ: begin
                n_state = rbd_pkg::S_IDLE;
            end
            default: begin
                n_state = rbd_pkg::S_IDLE;
            end
        endcase
    end

    rbd_ram #(
        .WIDTH (rbd_pkg::ELEMENT_WIDTH),
        .DEPTH (rbd_pkg::CAPACITY),
        .AW    (rbd_pkg::PTR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (i_item_data[rbd_pkg::ELEMENT_WIDTH-1:0]),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rbd_pkg::S_IDLE;
            r_front     <= '0;
            r_back      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_front <= n_front;
                r_back  <= n_back;
                r_count <= n_count;
            end
            // Load a new result, else drop a drained one.
            if ((accept && !pop_ok) || (r_state == rbd_pkg::S_READ)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the output beat; the popped word is loaded in the S_READ state, after the status and count.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_status <= status;
            r_out_count  <= n_count;
            r_out_data   <= '0;
        end else if (r_state == rbd_pkg::S_READ) begin
            r_out_data <= mem_rdata;
        end
    end

    assign data_ext  = {64'd0, r_out_data};
    assign count_ext = {5'd0, r_out_count};

    assign o_out_valid   = r_out_valid;
    assign o_out_data    = data_ext[63:0];
    assign o_status      = r_out_status;
    assign o_count_after = count_ext[4:0];

endmodule

@@ src/rbd_checker.sv @@
// Port-level assertions for the ring buffer deque, bound to the top level.
`timescale 1ns / 1ps
`include "ring_buffer_deque_macros.svh"
module rbd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [63:0] o_out_data,
    input logic [1:0]  o_status,
    input logic [4:0]  o_count_after
);

    localparam logic [5:0] CAP_6 = 6'(rbd_pkg::CAPACITY);

    logic [5:0]  count_6;
    logic [70:0] out_beat;
    logic        out_stall;
    logic        full_beat;
    logic        empty_beat;
    logic        empty_clean;

    assign count_6     = {1'b0, o_count_after};
    assign out_beat    = {o_out_data, o_status, o_count_after};
    assign out_stall   = o_out_valid && !i_out_ready;
    assign full_beat   = o_out_valid && (o_status == rbd_pkg::ST_FULL);
    assign empty_beat  = o_out_valid && (o_status == rbd_pkg::ST_EMPTY);
    assign empty_clean = (count_6 == 6'd0) && (o_out_data == 64'd0);

    // Reset leaves no result beat pending.
    `RBD_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !o_out_valid, "result beat after reset")

    // A rejected push reports a full queue.
    `RBD_ASSERT(a_full_count, full_beat |-> (count_6 == CAP_6), "full status below capacity")

    // A rejected pop reports an empty queue and no data.
    `RBD_ASSERT(a_empty_pop, empty_beat |-> empty_clean, "empty status with data or count")

    // A stalled result beat holds.
    `RBD_ASSERT(a_out_hold, out_stall |=> (o_out_valid && $stable(out_beat)), "stalled beat changed")

    // A stalled result blocks the input.
    `RBD_ASSERT(a_in_stall, out_stall |-> !o_in_ready, "input taken while output stalled")

endmodule

bind ring_buffer_deque rbd_checker u_rbd_checker (.*);

@@ verif/tb_ring_buffer_deque.sv @@
// Testbench of the ring buffer deque: directed and random push/pop traffic against a behavioral deque.
`timescale 1ns / 1ps
module tb_ring_buffer_deque;

    localparam int NUM_RANDOM  = 1600;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 200;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] data;
    } t_deque_op;

    typedef struct packed {
        logic [63:0] data;
        logic [1:0]  status;
        logic [4:0]  count;
    } t_deque_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic [1:0]  i_action      = rbd_pkg::ACT_PUSH_END;
    logic [63:0] i_item_data   = '0;
    logic        i_out_ready   = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [63:0] o_out_data;
    logic [1:0]  o_status;
    logic [4:0]  o_count_after;

    // Behavioral copy of the deque state.
    logic [rbd_pkg::ELEMENT_WIDTH-1:0] shadow_mem [rbd_pkg::CAPACITY];
    logic [rbd_pkg::PTR_W-1:0]         head_idx   = '0;
    logic [rbd_pkg::PTR_W-1:0]         tail_idx   = '0;
    logic [rbd_pkg::CNT_W-1:0]         fill_level = '0;

    t_deque_op     pending_q [$];
    t_deque_result expected_q [$];
    t_deque_op     next_op;
    t_deque_result got_beat;
    t_deque_result want_beat;

    int  item_total   = 0;
    int  accept_total = 0;
    int  fail_total   = 0;
    int  cycle_count  = 0;
    int  tx_wait      = 0;
    int  rx_wait      = 0;
    bit  tx_burst     = 1'b0;
    bit  rx_burst     = 1'b0;
    bit  hold_off     = 1'b0;

    ring_buffer_deque u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_item_data   (i_item_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data),
        .o_status      (o_status),
        .o_count_after (o_count_after)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [rbd_pkg::PTR_W-1:0] wrap_inc(
        input logic [rbd_pkg::PTR_W-1:0] idx
    );
        return (idx == rbd_pkg::PTR_W'(rbd_pkg::CAPACITY - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [rbd_pkg::PTR_W-1:0] wrap_dec(
        input logic [rbd_pkg::PTR_W-1:0] idx
    );
        return (idx == '0) ? rbd_pkg::PTR_W'(rbd_pkg::CAPACITY - 1) : idx - 1'b1;
    endfunction

    // Apply one action to the shadow deque and return the result beat it must produce.
    function automatic t_deque_result deque_apply(input logic [1:0] action,
                                                  input logic [63:0] word);
        t_deque_result res;
        res        = '0;
        res.status = rbd_pkg::ST_DONE;
        if (action == rbd_pkg::ACT_PUSH_END || action == rbd_pkg::ACT_PUSH_START) begin
            if (fill_level >= rbd_pkg::CAPACITY) begin
                res.status = rbd_pkg::ST_FULL;
            end else if (action == rbd_pkg::ACT_PUSH_END) begin
                if (fill_level != 0) tail_idx = wrap_inc(tail_idx);
                shadow_mem[tail_idx] = word[rbd_pkg::ELEMENT_WIDTH-1:0];
                fill_level++;
            end else begin
                if (fill_level != 0) head_idx = wrap_dec(head_idx);
                shadow_mem[head_idx] = word[rbd_pkg::ELEMENT_WIDTH-1:0];
                fill_level++;
            end
        end else begin
            if (fill_level == 0) begin
                res.status = rbd_pkg::ST_EMPTY;
            end else if (action == rbd_pkg::ACT_POP_END) begin
                res.data = 64'(shadow_mem[tail_idx]);
                fill_level--;
                if (fill_level != 0) tail_idx = wrap_dec(tail_idx);
            end else begin
                res.data = 64'(shadow_mem[head_idx]);
                fill_level--;
                if (fill_level != 0) head_idx = wrap_inc(head_idx);
            end
        end
        res.count = 5'(fill_level);
        return res;
    endfunction

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 9);
    endfunction

    task automatic flag_failure(input string msg);
        fail_total++;
        if (fail_total <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task automatic queue_op(input logic [1:0] action, input logic [63:0] data);
        pending_q.push_back('{action: action, data: data});
    endtask

    // Driver: present queued beats with random gaps, predict each accepted beat.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_q.push_back(deque_apply(i_action, i_item_data));
                accept_total++;
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the beat until taken
            end else if (tx_wait > 0) begin
                tx_wait--;
                i_in_valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                next_op = pending_q.pop_front();
                i_in_valid  <= 1'b1;
                i_action    <= next_op.action;
                i_item_data <= next_op.data;
                if ($urandom_range(0, 39) == 0) tx_burst = !tx_burst;
                tx_wait = hold_off ? 0 : draw_wait(tx_burst);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each result beat against the oldest prediction, stall at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got_beat = {o_out_data, o_status, o_count_after};
                if (expected_q.size() == 0) begin
                    flag_failure($sformatf("unexpected beat data=%h status=%0d count=%0d",
                                           got_beat.data, got_beat.status, got_beat.count));
                end else begin
                    want_beat = expected_q.pop_front();
                    if (got_beat.data !== want_beat.data ||
                        got_beat.status !== want_beat.status ||
                        got_beat.count !== want_beat.count) begin
                        flag_failure($sformatf(
                            "exp data=%h status=%0d count=%0d, got data=%h status=%0d count=%0d",
                            want_beat.data, want_beat.status, want_beat.count,
                            got_beat.data, got_beat.status, got_beat.count));
                    end
                end
                if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
                rx_wait = draw_wait(rx_burst);
            end
            if (hold_off) begin
                i_out_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Long receiver stalls so the output backs up and input stalls.
    initial begin
        while (accept_total < 300) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
        while (accept_total < 1000) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int random_total;
        int seg_len;
        int push_pct;
        int k;
        bit is_push;
        random_total = 0;

        // Pops on an empty queue, then a push and pop at each side and a pop on the emptied queue.
        queue_op(rbd_pkg::ACT_POP_END,    {64{1'b1}});
        queue_op(rbd_pkg::ACT_POP_START,  64'h0);
        queue_op(rbd_pkg::ACT_PUSH_END,   {64{1'b1}});
        queue_op(rbd_pkg::ACT_PUSH_START, 64'h0);
        queue_op(rbd_pkg::ACT_POP_START,  {64{1'b1}});
        queue_op(rbd_pkg::ACT_POP_END,    64'h0);
        queue_op(rbd_pkg::ACT_POP_END,    64'h0);
        // Fill from both sides, then push into the full queue.
        for (k = 0; k < rbd_pkg::CAPACITY; k++) begin
            queue_op(k[0] ? rbd_pkg::ACT_PUSH_START : rbd_pkg::ACT_PUSH_END,
                     (k == 0) ? {64{1'b1}} : (k == 1) ? 64'h0 : {$urandom, $urandom});
        end
        queue_op(rbd_pkg::ACT_PUSH_END,   64'hA5A5_A5A5_5A5A_5A5A);
        queue_op(rbd_pkg::ACT_PUSH_START, 64'h5A5A_5A5A_A5A5_A5A5);

        // Runs biased toward pushes or pops drive the queue to full and to empty.
        while (random_total < NUM_RANDOM) begin
            seg_len = $urandom_range(8, 64);
            case ($urandom_range(0, 2))
                0:       push_pct = 85;
                1:       push_pct = 50;
                default: push_pct = 15;
            endcase
            for (k = 0; k < seg_len; k++) begin
                is_push = ($urandom_range(0, 99) < push_pct);
                if (is_push)
                    queue_op($urandom_range(0, 1) ? rbd_pkg::ACT_PUSH_START
                                                  : rbd_pkg::ACT_PUSH_END,
                             {$urandom, $urandom});
                else
                    queue_op($urandom_range(0, 1) ? rbd_pkg::ACT_POP_START
                                                  : rbd_pkg::ACT_POP_END,
                             {$urandom, $urandom});
            end
            random_total += seg_len;
        end
        item_total = pending_q.size();

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accept_total < item_total) @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_total == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
